// File: rtl/core/pru_pkg.sv
// Package for the packed raw sample unpacker.
// Sample mode codes, accumulator widths and the word types shared by the core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

  localparam int BUF_W   = 22;
  localparam int CNT_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int SMP_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX  = 5'd21;
  localparam logic [CNT_W-1:0] BYTE_CNT = 5'd8;
  localparam logic [CNT_W-1:0] W12      = 5'd12;
  localparam logic [CNT_W-1:0] W14      = 5'd14;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_RAW12 = 2'd0;
  localparam mode_t MODE_RAW14 = 2'd1;
  localparam mode_t MODE_RAW16 = 2'd2;

  typedef struct packed {
    logic [SMP_W-1:0] sample_value;
    logic             final_sample;
  } word_t;

  typedef struct packed {
    logic  produced;
    word_t word;
  } unp_res_t;

endpackage

`default_nettype wire

// File: rtl/core/pru_in_if.sv
// Byte input channel: valid/ready handshake with raw byte and last flag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pru_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       last_byte;

  modport source (output valid, output raw_byte, output last_byte, input ready);
  modport sink   (input valid, input raw_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pru_out_if.sv
// Sample output channel: valid/ready handshake with sample value and final flag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pru_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  logic        final_sample;

  modport source (output valid, output sample_value, output final_sample, input ready);
  modport sink   (input valid, input sample_value, input final_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pru_unpack.sv
// Bit accumulator and sample extraction for the raw unpacker.
// Depends on pru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pru_unpack (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pru_pkg::mode_t   mode,
  input  wire logic             accept,
  input  wire logic [7:0]       raw_byte,
  input  wire logic             last_byte,
  output pru_pkg::unp_res_t     res
);
  import pru_pkg::*;

  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [BUF_W-1:0] shifted;
  logic [BUF_W-1:0] extracted;
  logic [CNT_W-1:0] cnt_add;
  logic [CNT_W-1:0] width;
  logic [CNT_W-1:0] sh;
  logic             mode16;

  assign mode16    = mode[1];
  assign width     = (mode == MODE_RAW12) ? W12 : W14;
  assign shifted   = {buf_r[BUF_W-BYTE_W-1:0], raw_byte};
  assign cnt_add   = cnt_r + BYTE_CNT;
  assign sh        = cnt_add - width;
  assign extracted = shifted >> sh;

  always_comb begin
    res.produced          = 1'b0;
    res.word.sample_value = '0;
    res.word.final_sample = last_byte;
    buf_nxt               = buf_r;
    cnt_nxt               = cnt_r;
    if (mode16) begin
      if (cnt_r == '0) begin
        buf_nxt = {{(BUF_W-BYTE_W){1'b0}}, raw_byte};
        cnt_nxt = BYTE_CNT;
      end else begin
        res.produced          = 1'b1;
        res.word.sample_value = {raw_byte, buf_r[BYTE_W-1:0]};
        buf_nxt               = '0;
        cnt_nxt               = '0;
      end
    end else begin
      buf_nxt = shifted;
      cnt_nxt = cnt_add;
      if (cnt_add >= width) begin
        res.produced = 1'b1;
        if (mode == MODE_RAW12) begin
          res.word.sample_value = {4'b0, extracted[11:0]};
        end else begin
          res.word.sample_value = {2'b0, extracted[13:0]};
        end
        cnt_nxt = sh;
        buf_nxt = shifted & ~({BUF_W{1'b1}} << sh);
      end
    end
    if (last_byte) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("bit count out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> cnt_r == '0 && buf_r == '0)
    else $error("accumulator not cleared after last byte");

  a_packed_left: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.produced && !mode16 |=> cnt_r < W14)
    else $error("too many bits left after packed sample");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pru_out_stage.sv
// Output register with skid slot for the unpacker result channel.
// Depends on pru_pkg and pru_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pru_out_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire pru_pkg::word_t word,
  output logic            in_ready,
  pru_out_if.source       out_ch
);
  import pru_pkg::*;

  word_t main_r, main_nxt;
  word_t skid_r, skid_nxt;
  logic  main_valid_r, main_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  logic  take;

  assign take     = main_valid_r && out_ch.ready;
  assign in_ready = !skid_valid_r;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = word;
        main_valid_nxt = load;
      end
    end else if (load) begin
      skid_nxt       = word;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = main_valid_r;
  assign out_ch.sample_value = main_r.sample_value;
  assign out_ch.final_sample = main_r.final_sample;

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held without output word");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ch.ready |=> main_valid_r && !skid_valid_r)
    else $error("skid word not moved to output");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !load)
    else $error("word loaded while skid slot full");
`endif

endmodule

`default_nettype wire

// File: rtl/core/packed_raw_sample_unpacker_core.sv
// Top level of the packed raw sample unpacker: mode register, accumulator, output stage.
// Depends on pru_pkg, pru_in_if, pru_out_if, pru_unpack and pru_out_stage.
//
//   port     dir  handshake      payload
//   in_ch    in   valid/ready    raw_byte[7:0], last_byte
//   out_ch   out  valid/ready    sample_value[15:0], final_sample
//   cfg_*    in   cfg_we         cfg_wdata[1:0] = sample_mode
//
// One byte per cycle while in_ch.ready is high; the sample that a byte completes is
// registered into the output register, or into the skid slot behind a stalled
// output. in_ch.ready drops only while the skid slot holds a word
// behind a stalled output. Synchronous active-low reset clears the mode,
// the accumulator and both output slots.
`timescale 1ns / 1ps
`default_nettype none

module packed_raw_sample_unpacker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pru_in_if.sink           in_ch,
  pru_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire pru_pkg::mode_t cfg_wdata
);
  import pru_pkg::*;

  mode_t    mode_r;
  unp_res_t res;
  logic     accept;
  logic     stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAW12;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = stage_ready;
  assign accept      = in_ch.valid && stage_ready;

  pru_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .accept    (accept),
    .raw_byte  (in_ch.raw_byte),
    .last_byte (in_ch.last_byte),
    .res       (res)
  );

  pru_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept && res.produced),
    .word     (res.word),
    .in_ready (stage_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/pru_unpack_checker.sv
// Sample checker for packed_raw_sample_unpacker_core: watches the byte, sample and mode ports.
// Models the bit accumulator, queues the samples it predicts and compares each word that leaves.
// Depends on pru_pkg, pru_in_if and pru_out_if.
`timescale 1ns / 1ps

module pru_unpack_checker (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pru_in_if              in_mon,
  pru_out_if             out_mon,
  input  wire logic      cfg_we,
  input  pru_pkg::mode_t cfg_wdata,
  output int             mismatches,
  output int             pending,
  output int             checked
);
  import pru_pkg::*;

  mode_t            mode_q;
  logic [BUF_W-1:0] acc_bits;
  logic [CNT_W-1:0] acc_cnt;
  word_t            queued_samples[$];

  // Shifts one byte into the accumulator; returns 1 when a sample completes.
  function automatic bit unpack_byte(input logic [7:0] b, input logic lst, output word_t w);
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] sh;
    logic [BUF_W-1:0] mask;
    logic [BUF_W-1:0] field;
    bit               got;
    got = 1'b0;
    w = '0;
    if (mode_q >= MODE_RAW16) begin
      // any pending bits count as the low byte
      if (acc_cnt == '0) begin
        acc_bits = BUF_W'(b);
        acc_cnt = BYTE_CNT;
      end else begin
        w.sample_value = {b, acc_bits[7:0]};
        acc_bits = '0;
        acc_cnt = '0;
        got = 1'b1;
      end
    end else begin
      width = (mode_q == MODE_RAW12) ? W12 : W14;
      mask = (mode_q == MODE_RAW12) ? BUF_W'(12'hFFF) : BUF_W'(14'h3FFF);
      acc_bits = {acc_bits[BUF_W-9:0], b};
      acc_cnt = acc_cnt + BYTE_CNT;
      if (acc_cnt >= width) begin
        sh = acc_cnt - width;
        field = (acc_bits >> sh) & mask;
        w.sample_value = field[SMP_W-1:0];
        acc_cnt = sh;
        acc_bits = acc_bits & ((BUF_W'(1) << sh) - BUF_W'(1));
        got = 1'b1;
      end
    end
    w.final_sample = lst;
    if (lst) begin
      acc_bits = '0;
      acc_cnt = '0;
    end
    return got;
  endfunction

  function automatic void flag(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    word_t want;
    word_t made;
    if (!rst_n) begin
      mode_q = MODE_RAW12;
      acc_bits = '0;
      acc_cnt = '0;
      queued_samples.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (queued_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t unexpected sample %h (final %b)", $time, out_mon.sample_value,
                     out_mon.final_sample);
          end
        end else begin
          want = queued_samples.pop_front();
          if (out_mon.sample_value !== want.sample_value) begin
            flag("sample_value", want.sample_value, out_mon.sample_value);
          end
          if (out_mon.final_sample !== want.final_sample) begin
            flag("final_sample", want.final_sample, out_mon.final_sample);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (unpack_byte(in_mon.raw_byte, in_mon.last_byte, made)) begin
          queued_samples.push_back(made);
        end
      end
      if (cfg_we) begin
        mode_q = cfg_wdata;
      end
    end
    pending = queued_samples.size();
  end

endmodule

// File: tb/tb.sv
// Top of the testbench for packed_raw_sample_unpacker_core: clock, reset, byte and mode stimulus.
// Checking is done by pru_unpack_checker; this module drives the ports and gives the verdict.
// Depends on pru_pkg, pru_in_if, pru_out_if, pru_unpack_checker and the core.
`timescale 1ns / 1ps

module tb;
  import pru_pkg::*;

  localparam mode_t MODE_SPARE  = 2'd3;
  localparam int    HOLD_CYCLES = 48;
  localparam int    PHASES      = 24;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  mode_t cfg_wdata;
  mode_t cur_mode;
  bit    calm;
  int    holdoffs_asked;
  int    holdoffs_done;
  int    bytes_sent;
  int    mode_writes;
  int    mismatches;
  int    pending;
  int    checked;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  packed_raw_sample_unpacker_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pru_unpack_checker sample_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[packed_raw_sample_unpacker_core] ERROR");
    $finish;
  end

  // sample receiver: random stalls, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    holdoffs_done = 0;
    forever begin
      @(negedge clk);
      if (holdoffs_done != holdoffs_asked) begin
        holdoffs_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int group_len(mode_t m);
    case (m)
      MODE_RAW12: return 3;
      MODE_RAW14: return 7;
      default: return 2;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!calm && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      in_ch.raw_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    in_ch.valid <= 1'b0;
    drain();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  initial begin : stimulus
    int   ph;
    int   left;
    int   len;
    int   guard;
    bit   close;
    bit   noisy;
    bit   paused;
    logic lst;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = MODE_RAW12;
    in_ch.valid = 1'b0;
    in_ch.raw_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    calm = 1'b0;
    holdoffs_asked = 0;
    bytes_sent = 0;
    mode_writes = 0;
    paused = 1'b0;
    cur_mode = MODE_RAW12;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 12-bit from reset: all ones, zeros, last completing a sample, lone last byte
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b1);
    // 14-bit group, then one byte left pending across a switch to 16-bit
    set_mode(MODE_RAW14);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    set_mode(MODE_RAW16);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // spare code acts as 16-bit; last byte pairs with a pending low byte
    set_mode(MODE_SPARE);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h01, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 6)
        0: set_mode(MODE_RAW12);
        1: set_mode(MODE_SPARE);
        default: set_mode(mode_t'($urandom_range(3)));
      endcase
      if (ph == 4) begin
        holdoffs_asked <= holdoffs_asked + 1;
        calm <= 1'b1;
      end
      if (ph == 9) calm <= 1'b1;
      left = $urandom_range(30, 75);
      while (left > 0) begin
        noisy = ($urandom_range(9) == 0);
        len = noisy ? $urandom_range(1, 12) : group_len(cur_mode) * $urandom_range(1, 5);
        close = 1'b1;
        if (len >= left) begin
          len = left;
          close = 1'($urandom_range(1));
        end
        for (int i = 0; i < len; i++) begin
          lst = close && (i == len - 1);
          if (noisy && $urandom_range(7) == 0) lst = 1'b1;
          send_byte(pick_byte(), lst);
        end
        left -= len;
        if (ph == 14 && !paused && left < 30) begin
          in_ch.valid <= 1'b0;
          drain();
          paused = 1'b1;
        end
      end
      calm <= 1'b0;
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    $display("Run: %0d bytes, %0d samples checked, %0d mode writes (all four codes,",
             bytes_sent, checked, mode_writes);
    $display("  switches mid-stream, last-byte flushes, one %0d-cycle output hold-off).",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("[packed_raw_sample_unpacker_core] OK");
    end else begin
      $display("[packed_raw_sample_unpacker_core] ERROR");
    end
    $finish;
  end

endmodule
